### rtl/i2cgs_pkg.sv
// ----------------------------------------------------------------------------
// i2cgs_pkg
// Shared types and constants of the gas sensor I2C poll master.
// ----------------------------------------------------------------------------
package i2cgs_pkg;

    // request codes carried in func
    localparam logic [1:0] FUNC_INIT    = 2'd1;
    localparam logic [1:0] FUNC_MEASURE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_DEVICE_ADDRESS     = 3'd0;
    localparam logic [2:0] CFG_INIT_COMMAND       = 3'd1;
    localparam logic [2:0] CFG_MEASURE_COMMAND    = 3'd2;
    localparam logic [2:0] CFG_ACK_TIMEOUT        = 3'd3;
    localparam logic [2:0] CFG_COMMAND_WAIT_TICKS = 3'd4;

    // configuration reset values
    localparam logic [6:0]  RST_DEVICE_ADDRESS     = 7'd88;
    localparam logic [15:0] RST_INIT_COMMAND       = 16'h2003;
    localparam logic [15:0] RST_MEASURE_COMMAND    = 16'h2008;
    localparam logic [3:0]  RST_ACK_TIMEOUT        = 4'd10;
    localparam logic [15:0] RST_COMMAND_WAIT_TICKS = 16'd20000;

    // byte slot that marks the address byte of the read frame
    localparam logic [2:0] READ_ADDR_SLOT = 3'd3;
    // byte slot of the check byte, which is dropped
    localparam logic [2:0] CHECK_SLOT     = 3'd2;
    // byte slot of the last read byte
    localparam logic [2:0] LAST_SLOT      = 3'd4;

    // bus phase, one tick each except idle, acknowledge high and wait, which can repeat
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_W_LOW   = 4'd3,
        PH_W_HIGH  = 4'd4,
        PH_A_LOW   = 4'd5,
        PH_A_HIGH  = 4'd6,
        PH_R_LOW   = 4'd7,
        PH_R_HIGH  = 4'd8,
        PH_M_LOW   = 4'd9,
        PH_M_HIGH  = 4'd10,
        PH_STOP_A  = 4'd11,
        PH_STOP_B  = 4'd12,
        PH_STOP_C  = 4'd13,
        PH_WAIT    = 4'd14
    } phase_t;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] init_command;
        logic [15:0] measure_command;
        logic [3:0]  ack_timeout;
        logic [15:0] command_wait_ticks;
    } cfg_t;

    // result of one tick
    typedef struct packed {
        logic        scl_level;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic        ack_error;
        logic [15:0] co2_value;
        logic [15:0] tvoc_value;
    } res_t;

endpackage

### rtl/i2cgs_core.sv
// ----------------------------------------------------------------------------
// i2cgs_core
// Bus sequencer: advances at most one SCL phase per accepted tick and computes
// the line levels and status that the tick produces.
// ----------------------------------------------------------------------------
module i2cgs_core
    import i2cgs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [1:0] func,
    input  logic       sda_in,
    input  cfg_t       cfg,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [31:0] read_acc_reg, read_acc_next;
    logic [3:0]  ack_wait_count_reg, ack_wait_count_next;
    logic [15:0] pause_count_reg, pause_count_next;
    logic        is_measure_reg, is_measure_next;
    logic        error_flag_reg, error_flag_next;
    logic [15:0] co2_store_reg, co2_store_next;
    logic [15:0] tvoc_store_reg, tvoc_store_next;

    logic [3:0]  ack_limit;
    logic [4:0]  ack_wait_inc;
    logic [15:0] cmd_word;
    logic [7:0]  read_shift;
    logic        done;
    logic        sdo;
    logic        scl;

    assign ack_limit    = (cfg.ack_timeout == 4'd0) ? 4'd1 : cfg.ack_timeout;
    assign ack_wait_inc = {1'b0, ack_wait_count_reg} + 5'd1;
    assign cmd_word     = is_measure_reg ? cfg.measure_command : cfg.init_command;
    assign read_shift   = {shift_byte_reg[6:0], sda_in};

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            bit_index_reg      <= '0;
            byte_index_reg     <= '0;
            shift_byte_reg     <= '0;
            read_acc_reg       <= '0;
            ack_wait_count_reg <= '0;
            pause_count_reg    <= '0;
            is_measure_reg     <= 1'b0;
            error_flag_reg     <= 1'b0;
            co2_store_reg      <= '0;
            tvoc_store_reg     <= '0;
        end else if (step_en) begin
            phase_reg          <= phase_next;
            bit_index_reg      <= bit_index_next;
            byte_index_reg     <= byte_index_next;
            shift_byte_reg     <= shift_byte_next;
            read_acc_reg       <= read_acc_next;
            ack_wait_count_reg <= ack_wait_count_next;
            pause_count_reg    <= pause_count_next;
            is_measure_reg     <= is_measure_next;
            error_flag_reg     <= error_flag_next;
            co2_store_reg      <= co2_store_next;
            tvoc_store_reg     <= tvoc_store_next;
        end
    end

    // next state
    always_comb begin
        phase_next          = phase_reg;
        bit_index_next      = bit_index_reg;
        byte_index_next     = byte_index_reg;
        shift_byte_next     = shift_byte_reg;
        read_acc_next       = read_acc_reg;
        ack_wait_count_next = ack_wait_count_reg;
        pause_count_next    = pause_count_reg;
        is_measure_next     = is_measure_reg;
        error_flag_next     = error_flag_reg;
        co2_store_next      = co2_store_reg;
        tvoc_store_next     = tvoc_store_reg;
        done                = 1'b0;

        case (phase_reg)
            PH_IDLE: begin
                if (func == FUNC_INIT || func == FUNC_MEASURE) begin
                    is_measure_next     = (func == FUNC_MEASURE);
                    error_flag_next     = 1'b0;
                    phase_next          = PH_START_A;
                    shift_byte_next     = {cfg.device_address, 1'b0};
                    byte_index_next     = 3'd0;
                    bit_index_next      = 3'd0;
                    ack_wait_count_next = 4'd0;
                end
            end
            PH_START_A: phase_next = PH_START_B;
            PH_START_B: phase_next = PH_W_LOW;
            PH_W_LOW:   phase_next = PH_W_HIGH;
            PH_W_HIGH: begin
                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                if (bit_index_reg == 3'd7) begin
                    bit_index_next      = 3'd0;
                    ack_wait_count_next = 4'd0;
                    phase_next          = PH_A_LOW;
                end else begin
                    bit_index_next = bit_index_reg + 3'd1;
                    phase_next     = PH_W_LOW;
                end
            end
            PH_A_LOW: phase_next = PH_A_HIGH;
            PH_A_HIGH: begin
                if (!sda_in) begin
                    ack_wait_count_next = 4'd0;
                    if (byte_index_reg == READ_ADDR_SLOT) begin
                        byte_index_next = 3'd0;
                        bit_index_next  = 3'd0;
                        shift_byte_next = 8'd0;
                        read_acc_next   = 32'd0;
                        phase_next      = PH_R_LOW;
                    end else if (byte_index_reg >= CHECK_SLOT) begin
                        phase_next = PH_STOP_A;
                    end else begin
                        // command high byte after the address, then low byte
                        byte_index_next = byte_index_reg + 3'd1;
                        shift_byte_next = (byte_index_reg == 3'd0) ? cmd_word[15:8]
                                                                   : cmd_word[7:0];
                        bit_index_next  = 3'd0;
                        phase_next      = PH_W_LOW;
                    end
                end else if (ack_wait_inc >= {1'b0, ack_limit}) begin
                    // acknowledge timed out
                    ack_wait_count_next = 4'd0;
                    error_flag_next     = 1'b1;
                    phase_next          = PH_STOP_A;
                end else begin
                    ack_wait_count_next = ack_wait_inc[3:0];
                end
            end
            PH_R_LOW: phase_next = PH_R_HIGH;
            PH_R_HIGH: begin
                shift_byte_next = read_shift;
                if (bit_index_reg == 3'd7) begin
                    bit_index_next = 3'd0;
                    if (byte_index_reg != CHECK_SLOT) begin
                        read_acc_next = {read_acc_reg[23:0], read_shift};
                    end
                    phase_next = PH_M_LOW;
                end else begin
                    bit_index_next = bit_index_reg + 3'd1;
                    phase_next     = PH_R_LOW;
                end
            end
            PH_M_LOW: phase_next = PH_M_HIGH;
            PH_M_HIGH: begin
                if (byte_index_reg >= LAST_SLOT) begin
                    co2_store_next  = read_acc_reg[31:16];
                    tvoc_store_next = read_acc_reg[15:0];
                    phase_next      = PH_STOP_A;
                end else begin
                    byte_index_next = byte_index_reg + 3'd1;
                    bit_index_next  = 3'd0;
                    shift_byte_next = 8'd0;
                    phase_next      = PH_R_LOW;
                end
            end
            PH_STOP_A: phase_next = PH_STOP_B;
            PH_STOP_B: phase_next = PH_STOP_C;
            PH_STOP_C: begin
                if (error_flag_reg || byte_index_reg != CHECK_SLOT) begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end else if (cfg.command_wait_ticks != 16'd0) begin
                    pause_count_next = cfg.command_wait_ticks;
                    phase_next       = PH_WAIT;
                end else if (is_measure_reg) begin
                    phase_next          = PH_START_A;
                    shift_byte_next     = {cfg.device_address, 1'b1};
                    byte_index_next     = READ_ADDR_SLOT;
                    bit_index_next      = 3'd0;
                    ack_wait_count_next = 4'd0;
                end else begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
            PH_WAIT: begin
                pause_count_next = pause_count_reg - 16'd1;
                if (pause_count_next == 16'd0) begin
                    if (is_measure_reg) begin
                        phase_next          = PH_START_A;
                        shift_byte_next     = {cfg.device_address, 1'b1};
                        byte_index_next     = READ_ADDR_SLOT;
                        bit_index_next      = 3'd0;
                        ack_wait_count_next = 4'd0;
                    end else begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // line levels of the phase being entered
    always_comb begin
        case (phase_next)
            PH_START_A: begin scl = 1'b1; sdo = 1'b0; end
            PH_START_B: begin scl = 1'b0; sdo = 1'b0; end
            PH_W_LOW:   begin scl = 1'b0; sdo = shift_byte_next[7]; end
            PH_W_HIGH:  begin scl = 1'b1; sdo = shift_byte_next[7]; end
            PH_A_LOW:   begin scl = 1'b0; sdo = 1'b1; end
            PH_R_LOW:   begin scl = 1'b0; sdo = 1'b1; end
            PH_M_LOW:   begin scl = 1'b0; sdo = (byte_index_next >= LAST_SLOT); end
            PH_M_HIGH:  begin scl = 1'b1; sdo = (byte_index_next >= LAST_SLOT); end
            PH_STOP_A:  begin scl = 1'b0; sdo = 1'b0; end
            PH_STOP_B:  begin scl = 1'b1; sdo = 1'b0; end
            default:    begin scl = 1'b1; sdo = 1'b1; end
        endcase
    end

    assign res.scl_level  = scl;
    assign res.sda_drive  = sdo;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.done_res   = done;
    assign res.ack_error  = error_flag_next;
    assign res.co2_value  = co2_store_next;
    assign res.tvoc_value = tvoc_store_next;

    // a sequence that reports done is back in idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.done_res |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    // the wait phase never holds an expired count
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_WAIT |-> pause_count_reg != 16'd0)
        else $error("wait phase with zero count");

    // an error is raised only by an acknowledge timeout, which goes to stop
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(error_flag_reg) |-> phase_reg == PH_STOP_A)
        else $error("error flag set outside a timeout");

    // the acknowledge slot starts with the bit counter cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_A_LOW |-> bit_index_reg == 3'd0)
        else $error("bit counter not cleared at acknowledge");

endmodule

### rtl/i2c_gas_sensor_poll_master.sv
// ----------------------------------------------------------------------------
// i2c_gas_sensor_poll_master
// Pin-level I2C master that runs init and measurement sequences on a gas
// sensor, at most one SCL phase per input tick.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick and yields exactly one result transfer
// holding the SCL/SDA drive levels for the next phase, busy/done/error status
// and the last CO2 and TVOC readings. One tick is taken per clock cycle: the
// sequencer state updates in the cycle a tick is accepted and the result is
// held in an output register, so s_tready stays high while it is empty or being
// drained, and throughput is one tick per cycle. A tick with func 1 or 2 while
// idle starts the init or measurement sequence; requests while busy are ignored.
// The user must configure via cfg_wr_en only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module i2c_gas_sensor_poll_master
    import i2cgs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // func [1:0], sda_in [2], zero pad
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // scl_level [0], sda_drive [1], busy_res [2],
                                   // done_res [3], ack_error [4], co2_value [20:5],
                                   // tvoc_value [36:21], zero pad
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t        cfg_reg;
    res_t        res;
    logic        accept;
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address     <= RST_DEVICE_ADDRESS;
            cfg_reg.init_command       <= RST_INIT_COMMAND;
            cfg_reg.measure_command    <= RST_MEASURE_COMMAND;
            cfg_reg.ack_timeout        <= RST_ACK_TIMEOUT;
            cfg_reg.command_wait_ticks <= RST_COMMAND_WAIT_TICKS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS:     cfg_reg.device_address     <= cfg_data[6:0];
                CFG_INIT_COMMAND:       cfg_reg.init_command       <= cfg_data;
                CFG_MEASURE_COMMAND:    cfg_reg.measure_command    <= cfg_data;
                CFG_ACK_TIMEOUT:        cfg_reg.ack_timeout        <= cfg_data[3:0];
                CFG_COMMAND_WAIT_TICKS: cfg_reg.command_wait_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // bus sequencer
    i2cgs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .func    (s_tdata[1:0]),
        .sda_in  (s_tdata[2]),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b000, res.tvoc_value, res.co2_value, res.ack_error,
                            res.done_res, res.busy_res, res.sda_drive, res.scl_level};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/tb_i2c_gas_sensor_poll_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_gas_sensor_poll_master
// Self-checking bench for the gas sensor I2C poll master. A behavioral slave
// answers each bus tick with an SDA level chosen from the predicted phase:
// ACK or NACK on acknowledge slots, chosen data on read slots, noise elsewhere.
// A scoreboard class keeps its own copy of the sequencer and compares every
// result transfer field by field. Directed init and measure sequences at the
// register extremes come first, then randomized phases with random settings.
// ----------------------------------------------------------------------------
module tb_i2c_gas_sensor_poll_master;
    import i2cgs_pkg::*;

    // func codes without a name in the package
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // byte slot of the second command byte
    localparam logic [2:0] CMD_LAST_SLOT = 3'd2;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum {READ_RANDOM, READ_ONES, READ_ZEROS} read_fill_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // func [1:0], sda_in [2], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // scl_level [0], sda_drive [1], busy_res [2],
                            // done_res [3], ack_error [4], co2_value [20:5],
                            // tvoc_value [36:21], zero pad
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    bit          idling_on = 1'b1;
    bit          hold_req  = 1'b0;
    bit          nack_cmd_end = 1'b0;
    int unsigned ack_pct   = 100;
    read_fill_t  read_fill = READ_RANDOM;
    int unsigned quiet_cycles = 0;

    // sequencer copy and store of expected bus ticks
    class poll_scoreboard;
        cfg_t        regs;
        phase_t      phase;
        logic [2:0]  bit_idx;
        logic [2:0]  byte_idx;
        logic [7:0]  shreg;
        logic [31:0] rd_acc;
        logic [3:0]  ack_wait;
        logic [15:0] pause;
        logic        measuring;
        logic        err_flag;
        logic [15:0] co2;
        logic [15:0] tvoc;
        res_t        expected_ticks[$];
        int unsigned fails;

        function new();
            regs.device_address     = RST_DEVICE_ADDRESS;
            regs.init_command       = RST_INIT_COMMAND;
            regs.measure_command    = RST_MEASURE_COMMAND;
            regs.ack_timeout        = RST_ACK_TIMEOUT;
            regs.command_wait_ticks = RST_COMMAND_WAIT_TICKS;
            phase     = PH_IDLE;
            bit_idx   = '0;
            byte_idx  = '0;
            shreg     = '0;
            rd_acc    = '0;
            ack_wait  = '0;
            pause     = '0;
            measuring = 1'b0;
            err_flag  = 1'b0;
            co2       = '0;
            tvoc      = '0;
            fails     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_DEVICE_ADDRESS:     regs.device_address = val[6:0];
                CFG_INIT_COMMAND:       regs.init_command = val;
                CFG_MEASURE_COMMAND:    regs.measure_command = val;
                CFG_ACK_TIMEOUT:        regs.ack_timeout = val[3:0];
                CFG_COMMAND_WAIT_TICKS: regs.command_wait_ticks = val;
                default: ;
            endcase
        endfunction

        // START followed by the address byte with the r/w bit
        function void open_frame(logic rw, logic [2:0] slot);
            phase    = PH_START_A;
            shreg    = {regs.device_address, rw};
            byte_idx = slot;
            bit_idx  = '0;
            ack_wait = '0;
        endfunction

        function void accept_tick(logic [1:0] func, logic sda);
            res_t        r;
            logic [15:0] cmd;
            logic [3:0]  limit;
            logic [1:0]  lines;
            logic        finished;
            finished = 1'b0;
            limit = (regs.ack_timeout == 4'd0) ? 4'd1 : regs.ack_timeout;
            case (phase)
                PH_IDLE: begin
                    if (func == FUNC_INIT || func == FUNC_MEASURE) begin
                        measuring = (func == FUNC_MEASURE);
                        err_flag  = 1'b0;
                        open_frame(1'b0, '0);
                    end
                end
                PH_START_A: phase = PH_START_B;
                PH_START_B: phase = PH_W_LOW;
                PH_W_LOW:   phase = PH_W_HIGH;
                PH_W_HIGH: begin
                    shreg = shreg << 1;
                    if (bit_idx == 3'd7) begin
                        bit_idx  = '0;
                        ack_wait = '0;
                        phase    = PH_A_LOW;
                    end else begin
                        bit_idx++;
                        phase = PH_W_LOW;
                    end
                end
                PH_A_LOW: phase = PH_A_HIGH;
                PH_A_HIGH: begin
                    if (!sda) begin
                        ack_wait = '0;
                        if (byte_idx == READ_ADDR_SLOT) begin
                            byte_idx = '0;
                            bit_idx  = '0;
                            shreg    = '0;
                            rd_acc   = '0;
                            phase    = PH_R_LOW;
                        end else if (byte_idx >= CMD_LAST_SLOT) begin
                            phase = PH_STOP_A;
                        end else begin
                            // slot 1 carries the high command byte
                            byte_idx++;
                            cmd   = measuring ? regs.measure_command : regs.init_command;
                            shreg = (byte_idx == 3'd1) ? cmd[15:8] : cmd[7:0];
                            bit_idx = '0;
                            phase   = PH_W_LOW;
                        end
                    end else if (ack_wait + 1 >= limit) begin
                        ack_wait = '0;
                        err_flag = 1'b1;
                        phase    = PH_STOP_A;
                    end else begin
                        ack_wait++;
                    end
                end
                PH_R_LOW: phase = PH_R_HIGH;
                PH_R_HIGH: begin
                    shreg = {shreg[6:0], sda};
                    if (bit_idx == 3'd7) begin
                        bit_idx = '0;
                        if (byte_idx != CHECK_SLOT)
                            rd_acc = {rd_acc[23:0], shreg};
                        phase = PH_M_LOW;
                    end else begin
                        bit_idx++;
                        phase = PH_R_LOW;
                    end
                end
                PH_M_LOW: phase = PH_M_HIGH;
                PH_M_HIGH: begin
                    if (byte_idx >= LAST_SLOT) begin
                        co2   = rd_acc[31:16];
                        tvoc  = rd_acc[15:0];
                        phase = PH_STOP_A;
                    end else begin
                        byte_idx++;
                        bit_idx = '0;
                        shreg   = '0;
                        phase   = PH_R_LOW;
                    end
                end
                PH_STOP_A: phase = PH_STOP_B;
                PH_STOP_B: phase = PH_STOP_C;
                PH_STOP_C: begin
                    if (err_flag || byte_idx != CMD_LAST_SLOT) begin
                        phase    = PH_IDLE;
                        finished = 1'b1;
                    end else if (regs.command_wait_ticks != 16'd0) begin
                        pause = regs.command_wait_ticks;
                        phase = PH_WAIT;
                    end else if (measuring) begin
                        open_frame(1'b1, READ_ADDR_SLOT);
                    end else begin
                        phase    = PH_IDLE;
                        finished = 1'b1;
                    end
                end
                PH_WAIT: begin
                    pause = pause - 16'd1;
                    if (pause == 16'd0) begin
                        if (measuring) begin
                            open_frame(1'b1, READ_ADDR_SLOT);
                        end else begin
                            phase    = PH_IDLE;
                            finished = 1'b1;
                        end
                    end
                end
                default: phase = PH_IDLE;
            endcase

            // bus levels of the phase just entered, {scl, sda}
            case (phase)
                PH_START_A:         lines = 2'b10;
                PH_START_B:         lines = 2'b00;
                PH_W_LOW:           lines = {1'b0, shreg[7]};
                PH_W_HIGH:          lines = {1'b1, shreg[7]};
                PH_A_LOW, PH_R_LOW: lines = 2'b01;
                PH_M_LOW:           lines = {1'b0, byte_idx >= LAST_SLOT};
                PH_M_HIGH:          lines = {1'b1, byte_idx >= LAST_SLOT};
                PH_STOP_A:          lines = 2'b00;
                PH_STOP_B:          lines = 2'b10;
                default:            lines = 2'b11;
            endcase
            r.scl_level  = lines[1];
            r.sda_drive  = lines[0];
            r.busy_res   = (phase != PH_IDLE);
            r.done_res   = finished;
            r.ack_error  = err_flag;
            r.co2_value  = co2;
            r.tvoc_value = tvoc;
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
                fails++;
            end
        endfunction

        function void check_tick_result(logic [39:0] d);
            res_t want;
            if (expected_ticks.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, d);
                fails++;
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("scl_level",  16'(want.scl_level), 16'(d[0]));
            compare_field("sda_drive",  16'(want.sda_drive), 16'(d[1]));
            compare_field("busy_res",   16'(want.busy_res),  16'(d[2]));
            compare_field("done_res",   16'(want.done_res),  16'(d[3]));
            compare_field("ack_error",  16'(want.ack_error), 16'(d[4]));
            compare_field("co2_value",  want.co2_value,      d[20:5]);
            compare_field("tvoc_value", want.tvoc_value,     d[36:21]);
        endfunction
    endclass

    poll_scoreboard poll_sb;

    i2c_gas_sensor_poll_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // transfer monitor: feed the scoreboard on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                poll_sb.accept_tick(s_tdata[1:0], s_tdata[2]);
            if (m_tvalid && m_tready)
                poll_sb.check_tick_result(m_tdata);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result receiver with short stalls and one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // slave side: level on SDA during the phase the next tick samples
    function automatic logic slave_sda();
        case (poll_sb.phase)
            PH_A_HIGH: begin
                // optionally refuse the last command byte to skip the command wait
                if (nack_cmd_end && poll_sb.byte_idx == CMD_LAST_SLOT)
                    return 1'b1;
                return ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
            end
            PH_R_HIGH: begin
                case (read_fill)
                    READ_ONES:  return 1'b1;
                    READ_ZEROS: return 1'b0;
                    default:    return 1'($urandom_range(0, 1));
                endcase
            end
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // one tick transfer, called and returning at a falling edge
    task automatic send_tick(input logic [1:0] func);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, slave_sda(), func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // finish the running sequence, then wait for all results
    task automatic run_to_idle();
        while (poll_sb.phase != PH_IDLE) send_tick(2'($urandom_range(0, 3)));
        s_tvalid <= 1'b0;
        while (poll_sb.expected_ticks.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic run_request(input logic [1:0] func);
        send_tick(func);
        while (poll_sb.phase != PH_IDLE) send_tick(2'($urandom_range(0, 3)));
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        poll_sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic write_config(input logic [6:0] addr, input logic [15:0] init_cmd,
                                input logic [15:0] meas_cmd, input logic [3:0] tmo,
                                input logic [15:0] wait_ticks);
        cfg_write(CFG_DEVICE_ADDRESS, {9'd0, addr});
        cfg_write(CFG_INIT_COMMAND, init_cmd);
        cfg_write(CFG_MEASURE_COMMAND, meas_cmd);
        cfg_write(CFG_ACK_TIMEOUT, {12'd0, tmo});
        cfg_write(CFG_COMMAND_WAIT_TICKS, wait_ticks);
        cfg_wr_en <= 1'b0;
    endtask

    // random ticks, requests likely whenever the sequencer is idle
    task automatic random_ticks(input int n);
        logic [1:0] func;
        for (int i = 0; i < n; i++) begin
            if (poll_sb.phase != PH_IDLE)
                func = 2'($urandom_range(0, 3));
            else if ($urandom_range(0, 9) < 7)
                func = $urandom_range(0, 1) ? FUNC_MEASURE : FUNC_INIT;
            else
                func = $urandom_range(0, 1) ? FUNC_TICK : FUNC_UNUSED;
            send_tick(func);
        end
    endtask

    // stimulus
    initial begin
        int p;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        poll_sb   = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: plain ticks, unused code, one init whose last
        // command byte times out so the long command wait is skipped
        send_tick(FUNC_TICK);
        send_tick(FUNC_UNUSED);
        nack_cmd_end = 1'b1;
        run_request(FUNC_INIT);
        run_to_idle();
        nack_cmd_end = 1'b0;

        // high extremes, no command wait
        write_config(7'h7F, 16'hFFFF, 16'h0000, 4'd15, 16'd0);
        read_fill = READ_ONES;
        run_request(FUNC_MEASURE);
        run_request(FUNC_INIT);
        // slave never acknowledges
        ack_pct = 0;
        run_request(FUNC_MEASURE);
        run_to_idle();

        // low extremes, timeout of zero acts as one
        write_config(7'h00, 16'h0000, 16'hFFFF, 4'd0, 16'd1);
        run_request(FUNC_MEASURE);
        ack_pct = 100;
        read_fill = READ_ZEROS;
        run_request(FUNC_MEASURE);
        run_to_idle();

        // longer command wait, single-tick timeout
        write_config(7'h2A, 16'hA55A, 16'h5AA5, 4'd1, 16'd30);
        run_request(FUNC_INIT);
        run_to_idle();

        // random phases, the last one without idling
        for (p = 0; p < 3; p++) begin
            write_config(7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)),
                         16'($urandom_range(0, 6)));
            ack_pct   = (p % 3 == 0) ? 100 : ((p % 3 == 1) ? 92 : 75);
            read_fill = read_fill_t'($urandom_range(0, 2));
            idling_on = (p != 2);
            if (p == 1)
                hold_req = 1'b1;
            random_ticks(15);
            run_to_idle();
        end

        repeat (5) @(negedge aclk);
        if (poll_sb.fails == 0 && poll_sb.expected_ticks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
